// ===== design/etwa_pkg.sv =====
package etwa_pkg;

  // Default build of the counter and tick length
  localparam int COUNTER_BITS_DEF = 16;
  localparam int US_PER_TICK_DEF  = 2;

  // Register and field widths
  localparam int MIN_LEAD_W = 10;
  localparam int MAX_SPAN_W = 26;
  localparam int SOON_W     = 10;
  localparam int REM_W      = 26;
  localparam int TIME_W     = 63;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  // Register reset values
  localparam logic [MIN_LEAD_W-1:0] MIN_LEAD_RST = 10'd128;
  localparam logic [MAX_SPAN_W-1:0] MAX_SPAN_RST = 26'd60000000;
  localparam logic [SOON_W-1:0]     SOON_RST     = 10'd32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOON     = 2'd2;

  // Command codes; codes five to seven act as a query
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_SET    = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [TIME_W-1:0] alarm_time_us;
  } in_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              status;
    logic              armed;
    logic              fired;
  } out_res_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic can_take;
    logic skid_full;
  } ob_stat_t;

endpackage

// ===== design/extended_timer_with_alarm.sv =====
// A taken request waits in the input register; its result is then captured in the
// result register and shown on out_data. Throughput: one request per cycle while the
// result side has room; the input register feeds one pass of add/compare logic into
// the result register, and a skid entry takes one more result while a result waits.
// Reset: synchronous active-low rst_n clears time, alarm and compare and restores the
// register defaults.
module extended_timer_with_alarm import etwa_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int US_PER_TICK  = US_PER_TICK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_res_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     in_v_r;
  in_req_t  in_req_r;
  logic     adv;
  out_res_t res;
  ob_stat_t ob_stat;
  cfg_wr_t  cfg;

  // Advance the held request whenever the result side has room for it
  assign adv      = in_v_r && ob_stat.can_take;
  // Take a new request when the input register is empty or empties this cycle
  assign in_ready = !in_v_r || adv;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  // Input register: hold the request until the core consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_data;
    end
  end

  // Core: time, alarm remainder and compare update in one pass
  etwa_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .US_PER_TICK  (US_PER_TICK)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (adv),
    .req   (in_req_r),
    .res   (res)
  );

  // Result register with skid entry
  etwa_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (adv),
    .up_data   (res),
    .stat      (ob_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A filled skid entry always sits behind a valid result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    ob_stat.skid_full |-> out_valid)
    else $error("skid entry held without a valid result");

  // Hold the request while the result side is full
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && ob_stat.skid_full) |=> in_v_r)
    else $error("request dropped while result side was full");

  // Cancel leaves no alarm pending and never fires
  a_cancel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_req_r.cmd == CMD_CANCEL) |-> (!res.armed && !res.fired))
    else $error("cancel left an alarm pending");

  // Rejection status only comes from a set alarm request
  a_status_from_set: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.status) |-> (in_req_r.cmd == CMD_SET))
    else $error("status raised by a request other than set alarm");

endmodule

// ===== design/etwa_div.sv =====
module etwa_div import etwa_pkg::*; #(
  parameter int US_PER_TICK = US_PER_TICK_DEF
) (
  input  logic [REM_W-1:0] dividend,
  output logic [REM_W-1:0] quotient
);

  localparam int Shift = 32;
  localparam int ProdW = REM_W + Shift + 1;
  localparam logic [Shift:0] Recip = (Shift+1)'((64'd1 << Shift) / US_PER_TICK);

  logic [ProdW-1:0] prod;
  logic [REM_W-1:0] q0;
  logic [REM_W+5-1:0] rmd;

  // Reciprocal estimate is exact or one low; fix it with one compare
  assign prod = ProdW'(dividend) * ProdW'(Recip);
  assign q0   = prod[Shift +: REM_W];
  assign rmd  = (REM_W+5)'(dividend) - (REM_W+5)'(q0) * (REM_W+5)'(US_PER_TICK);
  assign quotient = (rmd >= (REM_W+5)'(US_PER_TICK)) ? q0 + REM_W'(1) : q0;

endmodule

// ===== design/etwa_core.sv =====
module etwa_core import etwa_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int US_PER_TICK  = US_PER_TICK_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_wr_t  cfg,
  input  logic     adv,
  input  in_req_t  req,
  output out_res_t res
);

  localparam logic [63:0] PeriodUs = 64'(US_PER_TICK) << COUNTER_BITS;
  localparam logic [63:0] StepUs   = 64'(US_PER_TICK);

  logic [MIN_LEAD_W-1:0]   min_lead_r;
  logic [MAX_SPAN_W-1:0]   max_span_r;
  logic [SOON_W-1:0]       soon_r;
  logic [COUNTER_BITS-1:0] tick_r, tick_nxt;
  logic [63:0]             now_r, now_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [COUNTER_BITS-1:0] cmpv_r, cmpv_nxt;
  logic                    cmp_arm_r, cmp_arm_nxt;

  logic [COUNTER_BITS-1:0] tick_inc, tick_base;
  logic [63:0]             now_inc, tgt, lead, cmp_sum;
  logic                    wrap, match, rem_nz, rem_ge, dec_fire, dec_arm;
  logic                    past, too_soon, over, set_arm, is_tick;
  logic [REM_W-1:0]        rem_m, rem_dec, lead_c, div_in, div_q;
  logic                    status, fired;

  // Tick path
  assign tick_inc = tick_r + COUNTER_BITS'(1);
  assign now_inc  = now_r + StepUs;
  assign wrap     = (tick_inc == '0);
  assign match    = cmp_arm_r && (tick_inc == cmpv_r);
  assign rem_m    = match ? '0 : rem_r;
  assign rem_nz   = (rem_m != '0);
  assign rem_ge   = (64'(rem_m) >= PeriodUs);
  assign rem_dec  = REM_W'(64'(rem_m) - PeriodUs);
  assign dec_fire = (rem_dec == '0) || (rem_dec < REM_W'(soon_r));
  assign dec_arm  = (64'(rem_dec) < PeriodUs);

  // Set alarm path
  assign tgt      = {1'b0, req.alarm_time_us};
  assign past     = (tgt <= now_r);
  assign lead     = tgt - now_r;
  assign too_soon = (lead <= 64'(min_lead_r));
  assign over     = (lead > 64'(max_span_r));
  assign lead_c   = over ? max_span_r : lead[REM_W-1:0];
  assign set_arm  = (lead_c != '0) && (64'(lead_c) < PeriodUs);

  // One divider serves both ways of arming the compare
  assign is_tick   = (req.cmd == CMD_TICK);
  assign div_in    = is_tick ? rem_dec : lead_c;
  assign tick_base = is_tick ? tick_inc : tick_r;
  assign cmp_sum   = 64'(tick_base) + 64'(div_q);

  etwa_div #(
    .US_PER_TICK (US_PER_TICK)
  ) u_div (
    .dividend (div_in),
    .quotient (div_q)
  );

  always_comb begin
    tick_nxt    = tick_r;
    now_nxt     = now_r;
    rem_nxt     = rem_r;
    cmpv_nxt    = cmpv_r;
    cmp_arm_nxt = cmp_arm_r;
    status      = 1'b0;
    fired       = 1'b0;
    case (req.cmd)
      CMD_TICK: begin
        tick_nxt = tick_inc;
        now_nxt  = now_inc;
        if (match) begin
          rem_nxt     = '0;
          cmp_arm_nxt = 1'b0;
          fired       = 1'b1;
        end
        if (wrap && rem_nz && rem_ge) begin
          rem_nxt = rem_dec;
          if (dec_fire) begin
            rem_nxt     = '0;
            cmp_arm_nxt = 1'b0;
            fired       = 1'b1;
          end else if (dec_arm) begin
            cmpv_nxt    = cmp_sum[COUNTER_BITS-1:0];
            cmp_arm_nxt = 1'b1;
          end
        end
      end
      CMD_SET: begin
        if (past || too_soon) begin
          status = 1'b1;
        end else begin
          rem_nxt     = lead_c;
          cmp_arm_nxt = set_arm;
          if (set_arm) begin
            cmpv_nxt = cmp_sum[COUNTER_BITS-1:0];
          end
        end
      end
      CMD_CANCEL: begin
        rem_nxt     = '0;
        cmp_arm_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.time_us = now_nxt[TIME_W-1:0];
    res.status  = status;
    res.armed   = (rem_nxt != '0);
    res.fired   = fired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      now_r     <= '0;
      rem_r     <= '0;
      cmpv_r    <= '0;
      cmp_arm_r <= 1'b0;
    end else if (adv) begin
      tick_r    <= tick_nxt;
      now_r     <= now_nxt;
      rem_r     <= rem_nxt;
      cmpv_r    <= cmpv_nxt;
      cmp_arm_r <= cmp_arm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lead_r <= MIN_LEAD_RST;
      max_span_r <= MAX_SPAN_RST;
      soon_r     <= SOON_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_MIN_LEAD: min_lead_r <= cfg.wdata[MIN_LEAD_W-1:0];
        CFG_MAX_SPAN: max_span_r <= cfg.wdata[MAX_SPAN_W-1:0];
        CFG_SOON:     soon_r     <= cfg.wdata[SOON_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/etwa_outbuf.sv =====
module etwa_outbuf import etwa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  out_res_t up_data,
  output ob_stat_t stat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  logic     out_v_r, sk_v_r;
  out_res_t out_d_r, sk_d_r;
  logic     push, pop;

  assign stat.can_take  = !sk_v_r;
  assign stat.skid_full = sk_v_r;
  assign push = up_valid && !sk_v_r;
  assign pop  = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (pop) begin
      if (sk_v_r) begin
        sk_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      if (out_v_r) begin
        sk_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_d_r <= sk_v_r ? sk_d_r : up_data;
    end else if (push) begin
      if (out_v_r) begin
        sk_d_r <= up_data;
      end else begin
        out_d_r <= up_data;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== dv/extended_timer_with_alarm_test.sv =====
module extended_timer_with_alarm_test;
  import etwa_pkg::*;

  localparam int CB = COUNTER_BITS_DEF;
  // One full counter period in microseconds
  localparam logic [63:0] WRAP_US = (64'd1 << COUNTER_BITS_DEF) * 64'(US_PER_TICK_DEF);
  // Command codes beyond the defined set; the block treats them as a query
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  // Register slot with nothing behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int LONG_STALL = 300;
  localparam int CYCLE_LIMIT = 100_000;
  // Random requests per phase, and how far the counter may be run to a compare
  localparam int PHASE_STEPS = 5;
  localparam int FF_REACH = 40;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [TIME_W-1:0] tgt;
    logic [7:0]        reps;
    logic              typed;
    out_res_t          want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_req_t in_data;
  logic out_valid;
  logic out_ready;
  out_res_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the timer: counter, time base, alarm remainder and compare
  logic [CB-1:0]         cnt_now;
  logic [63:0]           epoch_us;
  logic [REM_W-1:0]      alarm_left;
  logic [CB-1:0]         match_cnt;
  logic                  match_on;
  // Shadow of the registers
  logic [MIN_LEAD_W-1:0] lead_floor;
  logic [MAX_SPAN_W-1:0] span_cap;
  logic [SOON_W-1:0]     soon_cap;

  out_res_t due_results[$];
  out_res_t want;
  int mismatches = 0;
  int cycles = 0;
  int stall_ask = 0;
  int stall_seen;
  bit quiet = 1'b0;

  extended_timer_with_alarm dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] system_time();
    return epoch_us + 64'(cnt_now) * 64'(US_PER_TICK_DEF);
  endfunction

  function automatic logic [TIME_W-1:0] noise63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic out_res_t outcome(input int t, input int s, input int a, input int f);
    out_res_t o;
    o.time_us = TIME_W'(t);
    o.status  = s[0];
    o.armed   = a[0];
    o.fired   = f[0];
    return o;
  endfunction

  function automatic plan_row_t plan_row(input logic [2:0] c, input logic [TIME_W-1:0] t,
                                         input int n, input logic typed,
                                         input out_res_t w);
    plan_row_t p;
    p.cmd   = c;
    p.tgt   = t;
    p.reps  = 8'(n);
    p.typed = typed;
    p.want  = w;
    return p;
  endfunction

  // Apply one request to the shadow timer and return the result it should produce.
  function automatic out_res_t advance_timer(input in_req_t r);
    out_res_t o;
    logic [63:0] now;
    logic [63:0] tgt;
    logic [63:0] lead;
    o = '0;
    case (r.cmd)
      CMD_TICK: begin
        cnt_now = cnt_now + CB'(1);
        // Compare is tested on the new count, before any wrap handling
        if (match_on && cnt_now == match_cnt) begin
          alarm_left = '0;
          match_on = 1'b0;
          o.fired = 1'b1;
        end
        if (cnt_now == '0) begin
          epoch_us = epoch_us + WRAP_US;
          // Drop one period only when at least a period is left
          if (alarm_left != '0 && 64'(alarm_left) >= WRAP_US) begin
            alarm_left = alarm_left - WRAP_US[REM_W-1:0];
            if (alarm_left == '0 || alarm_left < REM_W'(soon_cap)) begin
              alarm_left = '0;
              match_on = 1'b0;
              o.fired = 1'b1;
            end else if (64'(alarm_left) < WRAP_US) begin
              match_cnt = cnt_now + CB'(alarm_left / US_PER_TICK_DEF);
              match_on = 1'b1;
            end
          end
        end
      end
      CMD_SET: begin
        now = system_time();
        tgt = {1'b0, r.alarm_time_us};
        if (tgt <= now) begin
          o.status = 1'b1;
        end else begin
          lead = tgt - now;
          if (lead <= 64'(lead_floor)) begin
            o.status = 1'b1;
          end else begin
            if (lead > 64'(span_cap)) lead = 64'(span_cap);
            match_on = 1'b0;
            alarm_left = lead[REM_W-1:0];
            // Within one period the compare takes over at once
            if (alarm_left != '0 && lead < WRAP_US) begin
              match_cnt = cnt_now + CB'(alarm_left / US_PER_TICK_DEF);
              match_on = 1'b1;
            end
          end
        end
      end
      CMD_CANCEL: begin
        alarm_left = '0;
        match_on = 1'b0;
      end
      default: ;
    endcase
    now = system_time();
    o.time_us = now[TIME_W-1:0];
    o.armed = (alarm_left != '0);
    return o;
  endfunction

  // Choose an alarm target around the interesting leads: in the past, at the
  // minimum lead, very short, near whole periods (exact zero and soon-limit
  // firing), near the clamp, inside one period, and fully random.
  function automatic logic [TIME_W-1:0] pick_alarm_target();
    logic [63:0] now;
    logic [63:0] lead;
    logic [63:0] t;
    now = system_time();
    case ($urandom_range(0, 9))
      0: begin
        lead = 64'($urandom_range(0, 3));
        t = (now >= lead) ? now - lead : 64'd0;
        return t[TIME_W-1:0];
      end
      1, 2: lead = 64'(lead_floor) + 64'($urandom_range(0, 2));
      3: lead = 64'($urandom_range(1, 6));
      4: lead = WRAP_US * 64'($urandom_range(1, 3)) - 64'd4 + 64'($urandom_range(0, 8));
      5: lead = WRAP_US * 64'($urandom_range(1, 3)) + 64'(soon_cap) - 64'd3 +
                64'($urandom_range(0, 6));
      6: lead = 64'(span_cap) + 64'($urandom_range(0, 2));
      7: lead = 64'($urandom_range(1, 32'(WRAP_US) - 1));
      8: return noise63();
      default: lead = 64'($urandom & 32'h3FF_FFFF);
    endcase
    t = now + lead;
    return t[TIME_W-1:0];
  endfunction

  // Offer one request, hold it until taken, then log what it should return.
  task automatic issue(input logic [2:0] c, input logic [TIME_W-1:0] t,
                       input logic typed, input out_res_t w);
    in_req_t r;
    out_res_t p;
    r.cmd = c;
    r.alarm_time_us = t;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = advance_timer(r);
    due_results.push_back(typed ? w : p);
    // Occasionally drop valid for a burst
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MIN_LEAD: lead_floor = data[MIN_LEAD_W-1:0];
      CFG_MAX_SPAN: span_cap = data[MAX_SPAN_W-1:0];
      CFG_SOON: soon_cap = data[SOON_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid and wait out every pending result plus the pipeline depth.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random ready bursts, plus one long hold-off on request so
  // the block backs up and deasserts in_ready.
  initial begin
    out_ready = 1'b0;
    stall_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && rst_n && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each taken result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: time %0d status %0b armed %0b fired %0b",
                   out_data.time_us, out_data.status, out_data.armed, out_data.fired);
      end else begin
        want = due_results.pop_front();
        if (out_data.time_us !== want.time_us || out_data.status !== want.status ||
            out_data.armed !== want.armed || out_data.fired !== want.fired) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp time %0d st %0b arm %0b fire %0b, got time %0d st %0b arm %0b fire %0b",
                     want.time_us, want.status, want.armed, want.fired,
                     out_data.time_us, out_data.status, out_data.armed, out_data.fired);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    int ff_at;
    int pick;
    logic [CB-1:0] gap;
    bit keep;

    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    cnt_now = '0;
    epoch_us = '0;
    alarm_left = '0;
    match_cnt = '0;
    match_on = 1'b0;
    lead_floor = MIN_LEAD_RST;
    span_cap = MAX_SPAN_RST;
    soon_cap = SOON_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset register values. Rows with a typed
    // result carry fixed expected values; the rest use the shadow.
    plan.push_back(plan_row(CMD_READ, '0, 1, 1'b1, outcome(0, 0, 0, 0)));
    plan.push_back(plan_row(CMD_QUERY, '1, 1, 1'b1, outcome(0, 0, 0, 0)));
    plan.push_back(plan_row(CMD_TICK, '0, 1, 1'b1, outcome(2, 0, 0, 0)));
    // target in the past, equal to now, lead exactly at the minimum
    plan.push_back(plan_row(CMD_SET, '0, 1, 1'b1, outcome(2, 1, 0, 0)));
    plan.push_back(plan_row(CMD_SET, 63'd2, 1, 1'b1, outcome(2, 1, 0, 0)));
    plan.push_back(plan_row(CMD_SET, 63'd130, 1, 1'b1, outcome(2, 1, 0, 0)));
    plan.push_back(plan_row(CMD_SET, 63'd131, 1, 1'b1, outcome(2, 0, 1, 0)));
    plan.push_back(plan_row(CMD_CANCEL, '0, 1, 1'b1, outcome(2, 0, 0, 0)));
    // farthest target clamps to the maximum span
    plan.push_back(plan_row(CMD_SET, '1, 1, 1'b1, outcome(2, 0, 1, 0)));
    plan.push_back(plan_row(CMD_SPARE_HI, '0, 1, 1'b1, outcome(2, 0, 1, 0)));
    plan.push_back(plan_row(CMD_SPARE_LO, '1, 1, 1'b0, '0));
    plan.push_back(plan_row(3'd6, noise63(), 1, 1'b0, '0));
    // lead 200 replaces the pending alarm; compare fires at 202 us
    plan.push_back(plan_row(CMD_SET, 63'd202, 1, 1'b1, outcome(2, 0, 1, 0)));
    plan.push_back(plan_row(CMD_TICK, '0, 99, 1'b0, '0));
    plan.push_back(plan_row(CMD_TICK, '0, 1, 1'b1, outcome(202, 0, 0, 1)));
    // odd lead rounds the compare offset down
    plan.push_back(plan_row(CMD_SET, 63'd403, 1, 1'b0, '0));
    plan.push_back(plan_row(CMD_TICK, '0, 100, 1'b0, '0));
    // cancel disarms the compare; ticks past it must not fire
    plan.push_back(plan_row(CMD_SET, 63'd531, 1, 1'b0, '0));
    plan.push_back(plan_row(CMD_CANCEL, noise63(), 1, 1'b0, '0));
    plan.push_back(plan_row(CMD_TICK, '0, 70, 1'b0, '0));
    plan.push_back(plan_row(CMD_SET, 63'h4000_0000_0000_0000, 1, 1'b0, '0));
    plan.push_back(plan_row(CMD_READ, '1, 1, 1'b0, '0));
    plan.push_back(plan_row(CMD_CANCEL, '0, 1, 1'b0, '0));

    foreach (plan[i])
      repeat (plan[i].reps) issue(plan[i].cmd, plan[i].tgt, plan[i].typed, plan[i].want);

    // Random phases, each under its own register setting. Phase 0 keeps the
    // reset values; later phases hit both extremes, masking of wide write
    // data, the spare slot, and random mixes.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: begin
            write_reg(CFG_MIN_LEAD, '0);
            write_reg(CFG_MAX_SPAN, '0);
            write_reg(CFG_SOON, '0);
          end
          2: begin
            write_reg(CFG_MIN_LEAD, '1);
            write_reg(CFG_MAX_SPAN, '1);
            write_reg(CFG_SOON, '1);
          end
          3: begin
            write_reg(CFG_MIN_LEAD, '0);
            write_reg(CFG_MAX_SPAN, CFG_DATA_W'(2 * WRAP_US + $urandom_range(0, 1000)));
            write_reg(CFG_SOON, CFG_DATA_W'($urandom_range(0, 64)));
          end
          4: begin
            write_reg(CFG_MIN_LEAD, CFG_DATA_W'($urandom));
            write_reg(CFG_MAX_SPAN, CFG_DATA_W'($urandom));
            write_reg(CFG_SOON, CFG_DATA_W'($urandom));
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
          end
          default: begin
            write_reg(CFG_MIN_LEAD, CFG_DATA_W'($urandom_range(0, 200)));
            write_reg(CFG_MAX_SPAN, CFG_DATA_W'($urandom_range(32'(WRAP_US),
                                                                32'(4 * WRAP_US))));
            write_reg(CFG_SOON, CFG_DATA_W'($urandom_range(1, 1023)));
          end
        endcase
        cfg_we <= 1'b0;
      end

      // Ask the result side for its long hold-off while requests keep coming
      if (ph == 2) stall_ask++;

      ff_at = $urandom_range(0, PHASE_STEPS - 1);
      for (int a = 0; a < PHASE_STEPS; a++) begin
        // Run the tail of the test with both sides streaming
        if (ph == 5 && a == 2) quiet = 1'b1;

        if (a == ff_at) begin
          // Arm an alarm; when its compare is close, run the counter up to
          // just short of it, then tick across.
          issue(CMD_SET, pick_alarm_target(), 1'b0, '0);
          gap = match_cnt - cnt_now;
          if (match_on && gap != '0 && gap <= CB'(FF_REACH)) begin
            keep = quiet;
            quiet = 1'b1;
            repeat (int'(gap) - 1) issue(CMD_TICK, noise63(), 1'b0, '0);
            quiet = keep;
          end
          repeat ($urandom_range(1, 8)) issue(CMD_TICK, noise63(), 1'b0, '0);
        end

        pick = $urandom_range(0, 99);
        if (pick < 30)
          repeat ($urandom_range(1, 12)) issue(CMD_TICK, noise63(), 1'b0, '0);
        else if (pick < 55)
          issue(CMD_SET, pick_alarm_target(), 1'b0, '0);
        else if (pick < 63)
          issue(CMD_CANCEL, noise63(), 1'b0, '0);
        else if (pick < 71)
          issue(CMD_READ, noise63(), 1'b0, '0);
        else if (pick < 79)
          issue(CMD_QUERY, noise63(), 1'b0, '0);
        else if (pick < 85)
          issue(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), noise63(), 1'b0, '0);
        else begin
          // set, then tick toward it
          issue(CMD_SET, pick_alarm_target(), 1'b0, '0);
          repeat ($urandom_range(1, 30)) issue(CMD_TICK, noise63(), 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
